// ----- sv/sssa_pkg.sv -----
// Shared types, constants and helpers of the sorted series aligner.
`timescale 1ns / 1ps

package sssa_pkg;

    // Point store sizing
    localparam int POINT_DEPTH = 32768;
    localparam int PTR_W       = $clog2(POINT_DEPTH);
    localparam int CNT_W       = $clog2(POINT_DEPTH + 1);

    // Field widths
    localparam int OP_W    = 2;
    localparam int MODE_W  = 2;
    localparam int DATE_W  = 27;
    localparam int TIME_W  = 18;
    localparam int BITS_W  = 32;
    localparam int SCALE_W = 20;
    localparam int KEY_W   = DATE_W + SCALE_W;

    // Key is date * KEY_SCALE + time
    localparam int KEY_SCALE = 1000000;

    // IEEE single exponent field
    localparam int EXP_LSB = 23;
    localparam int EXP_W   = 8;

    typedef enum logic [OP_W-1:0] {
        OP_CLEAR  = 2'd0,
        OP_APPEND = 2'd1,
        OP_ALIGN  = 2'd2
    } t_op;

    typedef enum logic [MODE_W-1:0] {
        MODE_EXACT     = 2'd0,
        MODE_FWD_FILL  = 2'd1,
        MODE_ZERO_FILL = 2'd2,
        MODE_REV_FILL  = 2'd3
    } t_mode;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_WRITE,
        ST_SETUP,
        ST_WALK
    } t_state;

    // One stored point
    typedef struct packed {
        logic [KEY_W-1:0]  key;
        logic [BITS_W-1:0] bits;
    } t_entry;

    // Outcome of a key compare, stored key against bar key
    typedef struct packed {
        logic lt;
        logic eq;
        logic gt;
    } t_cmp_res;

    // True when the exponent field is not all ones
    function automatic logic is_finite(input logic [BITS_W-1:0] bits);
        return bits[EXP_LSB +: EXP_W] != {EXP_W{1'b1}};
    endfunction

endpackage

// ----- sv/sssa_ram.sv -----
// Point store: one write port, one registered read port.
`timescale 1ns / 1ps

module sssa_ram (
    input  logic                       i_clk,
    input  logic                       i_we,
    input  logic [sssa_pkg::PTR_W-1:0] i_waddr,
    input  sssa_pkg::t_entry           i_wdata,
    input  logic                       i_re,
    input  logic [sssa_pkg::PTR_W-1:0] i_raddr,
    output sssa_pkg::t_entry           o_rdata
);
    import sssa_pkg::*;

    t_entry r_mem [POINT_DEPTH];
    t_entry r_rdata;

    // Write appended points, register read data
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ----- sv/sssa_cmp.sv -----
// Shared key comparator used on every step of the cursor walk.
`timescale 1ns / 1ps

module sssa_cmp (
    input  logic [sssa_pkg::KEY_W-1:0] i_point_key,
    input  logic [sssa_pkg::KEY_W-1:0] i_bar_key,
    output sssa_pkg::t_cmp_res         o_res
);
    import sssa_pkg::*;

    // Order the stored point against the bar
    always_comb begin
        o_res.lt = i_point_key < i_bar_key;
        o_res.eq = i_point_key == i_bar_key;
        o_res.gt = i_point_key > i_bar_key;
    end

endmodule

// ----- sv/sorted_series_align_with_fill.sv -----
// Top level: sequencer that walks a cursor over the point store for each bar.
// Clear and unknown items leave busy low, and the next item may follow.
// Append holds busy while the point is written to the store; a full store drops it and flags overflow.
// Align passes through setup and a cursor walk, then strobes its result; the walk
// steps over points with the store read and key compare running one point per
// cycle. The receiver cannot stall, so a result never blocks the next item.
// Reset is synchronous: counters, flags and mode clear; the store is not cleared.
`timescale 1ns / 1ps

module sorted_series_align_with_fill (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        start,
    output logic                        busy,
    input  logic [sssa_pkg::OP_W-1:0]   i_operation,
    input  logic [sssa_pkg::DATE_W-1:0] i_date,
    input  logic [sssa_pkg::TIME_W-1:0] i_time_req,
    input  logic [sssa_pkg::BITS_W-1:0] i_sample_bits,
    input  logic                        i_cfg_we,
    input  logic [sssa_pkg::MODE_W-1:0] i_cfg_data,
    output logic                        o_strobe,
    output logic                        o_present,
    output logic [sssa_pkg::BITS_W-1:0] o_aligned_bits,
    output logic                        o_store_overflow
);
    import sssa_pkg::*;

    // Control state
    t_state             r_state, n_state;
    t_mode              r_mode, n_mode;
    logic [CNT_W-1:0]   r_total, n_total;
    logic [CNT_W-1:0]   r_cursor, n_cursor;
    logic               r_walk, n_walk;
    logic               r_last_present, n_last_present;
    logic [BITS_W-1:0]  r_last_bits, n_last_bits;
    logic               r_ovf, n_ovf;
    logic               r_strobe, n_strobe;

    // Payload
    logic [KEY_W-1:0]   r_key, n_key;
    logic [BITS_W-1:0]  r_sample, n_sample;
    logic               r_present, n_present;
    logic [BITS_W-1:0]  r_out_bits, n_out_bits;
    logic               r_out_ovf, n_out_ovf;

    // Store and compare unit hookup
    logic               ram_we;
    logic               ram_re;
    logic [PTR_W-1:0]   ram_raddr;
    t_entry             ram_wdata;
    t_entry             ram_rdata;
    t_cmp_res           cmp_res;

    // Key of the incoming item
    logic [KEY_W-1:0]   w_prod;
    logic [KEY_W-1:0]   w_key;
    logic               w_accept;

    assign w_accept = start && !busy;
    assign w_prod   = KEY_W'(i_date) * KEY_W'(KEY_SCALE);
    assign w_key    = w_prod + KEY_W'(i_time_req);

    assign ram_wdata = '{key: r_key, bits: r_sample};

    sssa_ram u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_total[PTR_W-1:0]),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    sssa_cmp u_cmp (
        .i_point_key (ram_rdata.key),
        .i_bar_key   (r_key),
        .o_res       (cmp_res)
    );

    // State and payload registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= ST_IDLE;
            r_mode         <= MODE_EXACT;
            r_total        <= '0;
            r_cursor       <= '0;
            r_walk         <= 1'b0;
            r_last_present <= 1'b0;
            r_last_bits    <= '0;
            r_ovf          <= 1'b0;
            r_strobe       <= 1'b0;
        end else begin
            r_state        <= n_state;
            r_mode         <= n_mode;
            r_total        <= n_total;
            r_cursor       <= n_cursor;
            r_walk         <= n_walk;
            r_last_present <= n_last_present;
            r_last_bits    <= n_last_bits;
            r_ovf          <= n_ovf;
            r_strobe       <= n_strobe;
        end
        r_key      <= n_key;
        r_sample   <= n_sample;
        r_present  <= n_present;
        r_out_bits <= n_out_bits;
        r_out_ovf  <= n_out_ovf;
    end

    // Sequencer: next state, store access and result
    always_comb begin
        logic              rev;
        logic              done;
        logic              match;
        logic              has;
        logic [BITS_W-1:0] bits;
        logic [CNT_W-1:0]  cur0;

        n_state        = r_state;
        n_mode         = r_mode;
        n_total        = r_total;
        n_cursor       = r_cursor;
        n_walk         = r_walk;
        n_last_present = r_last_present;
        n_last_bits    = r_last_bits;
        n_ovf          = r_ovf;
        n_strobe       = 1'b0;
        n_key          = r_key;
        n_sample       = r_sample;
        n_present      = r_present;
        n_out_bits     = r_out_bits;
        n_out_ovf      = r_out_ovf;
        ram_we         = 1'b0;
        ram_re         = 1'b0;
        ram_raddr      = '0;
        rev            = (r_mode == MODE_REV_FILL);
        done           = 1'b0;
        match          = 1'b0;
        has            = 1'b0;
        bits           = '0;
        cur0           = r_cursor;

        // Take a mode write
        if (i_cfg_we) begin
            n_mode = t_mode'(i_cfg_data);
        end

        unique case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    n_key    = w_key;
                    n_sample = i_sample_bits;
                    unique case (t_op'(i_operation))
                        OP_CLEAR: begin
                            n_total        = '0;
                            n_cursor       = '0;
                            n_walk         = 1'b0;
                            n_last_present = 1'b0;
                            n_last_bits    = '0;
                            n_ovf          = 1'b0;
                        end
                        OP_APPEND: begin
                            // Drop the point and flag it once the store is full
                            if (r_total < CNT_W'(POINT_DEPTH)) begin
                                n_state = ST_WRITE;
                            end else begin
                                n_ovf = 1'b1;
                            end
                        end
                        OP_ALIGN: begin
                            n_state = ST_SETUP;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ST_WRITE: begin
                ram_we  = 1'b1;
                n_total = r_total + 1'b1;
                n_state = ST_IDLE;
            end
            ST_SETUP: begin
                // Clamp the cursor; a first reverse bar starts at the top
                cur0 = (r_cursor > r_total) ? r_total : r_cursor;
                if (rev && !r_walk) begin
                    cur0 = r_total;
                end
                n_cursor = cur0;
                if (rev) begin
                    if (cur0 != '0) begin
                        ram_re    = 1'b1;
                        ram_raddr = PTR_W'(cur0 - 1'b1);
                        n_state   = ST_WALK;
                    end else begin
                        done = 1'b1;
                    end
                end else begin
                    if (cur0 < r_total) begin
                        ram_re    = 1'b1;
                        ram_raddr = PTR_W'(cur0);
                        n_state   = ST_WALK;
                    end else begin
                        done = 1'b1;
                    end
                end
            end
            ST_WALK: begin
                // Step past one point per cycle, reading the next candidate
                if (rev) begin
                    if (cmp_res.gt) begin
                        n_cursor = r_cursor - 1'b1;
                        if (n_cursor != '0) begin
                            ram_re    = 1'b1;
                            ram_raddr = PTR_W'(n_cursor - 1'b1);
                        end else begin
                            done = 1'b1;
                        end
                    end else begin
                        done  = 1'b1;
                        match = cmp_res.eq;
                    end
                end else begin
                    if (cmp_res.lt) begin
                        n_cursor = r_cursor + 1'b1;
                        if (n_cursor < r_total) begin
                            ram_re    = 1'b1;
                            ram_raddr = PTR_W'(n_cursor);
                        end else begin
                            done = 1'b1;
                        end
                    end else begin
                        done  = 1'b1;
                        match = cmp_res.eq;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase

        // Settle the bar: match, fill or nothing
        if (done) begin
            if (match) begin
                has  = 1'b1;
                bits = ram_rdata.bits;
            end else begin
                unique case (r_mode)
                    MODE_EXACT: begin
                        has = 1'b0;
                    end
                    MODE_FWD_FILL, MODE_REV_FILL: begin
                        has  = r_last_present;
                        bits = r_last_bits;
                    end
                    MODE_ZERO_FILL: begin
                        has = 1'b1;
                    end
                    default: begin
                        has = 1'b0;
                    end
                endcase
            end
            n_walk         = 1'b1;
            n_last_present = has;
            n_last_bits    = has ? bits : '0;
            n_strobe       = 1'b1;
            n_present      = has && is_finite(bits);
            n_out_bits     = (has && is_finite(bits)) ? bits : '0;
            n_out_ovf      = r_ovf;
            n_state        = ST_IDLE;
        end
    end

    assign busy             = (r_state != ST_IDLE);
    assign o_strobe         = r_strobe;
    assign o_present        = r_present;
    assign o_aligned_bits   = r_out_bits;
    assign o_store_overflow = r_out_ovf;

endmodule

// ----- sv/sssa_checker.sv -----
// Port-level checks of the aligner, bound to the top level.
`timescale 1ns / 1ps

module sssa_checker (
    input logic                        i_clk,
    input logic                        i_rst_n,
    input logic                        start,
    input logic                        busy,
    input logic [sssa_pkg::OP_W-1:0]   i_operation,
    input logic                        o_strobe,
    input logic                        o_present,
    input logic [sssa_pkg::BITS_W-1:0] o_aligned_bits
);
    import sssa_pkg::*;

    // A result strobe is preceded by a busy block
    a_strobe_after_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> $past(busy))
        else $error("result strobed without a preceding busy cycle");

    // An accepted align item makes the block busy
    a_align_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && i_operation == OP_ALIGN) |=> busy)
        else $error("align item accepted but block not busy");

    // A clear item gives no result and leaves the block ready
    a_clear_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && i_operation == OP_CLEAR) |=> (!busy && !o_strobe))
        else $error("clear item produced a result or busy");

    // An absent result carries zero bits
    a_absent_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && !o_present) |-> (o_aligned_bits == '0))
        else $error("absent result with nonzero bits");

    // A present result is finite
    a_present_finite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_present) |-> is_finite(o_aligned_bits))
        else $error("present result is not finite");

endmodule

bind sorted_series_align_with_fill sssa_checker u_sssa_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .start          (start),
    .busy           (busy),
    .i_operation    (i_operation),
    .o_strobe       (o_strobe),
    .o_present      (o_present),
    .o_aligned_bits (o_aligned_bits)
);
